/* rtl/wsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_INVALID = 2'd2,
		KIND_TRUNC   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_RIFF,
		ST_SEEKFMT,
		ST_SKIPFMT,
		ST_FMTBODY,
		ST_CHK_MUL,
		ST_CHK_CMP,
		ST_SEEKDATA,
		ST_SKIPDATA,
		ST_DATA,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RIFF,
		OP_CHUNK,
		OP_SKIP,
		OP_FMT,
		OP_DATA,
		OP_SKIP16
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  start;
		logic  out_load;
		kind_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic riff_done;
		logic riff_ok;
		logic chunk_done;
		logic tag_fmt;
		logic tag_data;
		logic size_zero;
		logic skip_one;
		logic fmt_last;
		logic sample_done;
		logic data_end;
		logic fmt_ok;
		logic skip_gt16;
	} status_t;

endpackage
`default_nettype wire

/* rtl/wsp_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsp_dp (
	input  wire logic                clk,
	input  wire logic [7:0]          data_byte,
	input  wire wsp_pkg::cmd_t       cmd,
	output wsp_pkg::status_t         status,
	output logic [1:0]               kind,
	output logic signed [31:0]       sample,
	output logic [31:0]              rate_hz,
	output logic [4:0]               channel_count,
	output logic [5:0]               sample_bits,
	output logic                     last
);

	logic [4:0]  byte_index_q;
	logic [31:0] tag_q;
	logic [31:0] size_q;
	logic [31:0] skip_left_q;
	logic [15:0] format_q;
	logic [15:0] channels_q;
	logic [31:0] rate_q;
	logic [31:0] byterate_q;
	logic [15:0] align_q;
	logic [15:0] bits_q;
	logic [31:0] data_left_q;
	logic [23:0] accum_q;
	logic [31:0] prod_q;

	logic [4:0]  idx;
	logic [31:0] size_next;
	logic [2:0]  bps;
	logic [1:0]  lane;
	logic [31:0] merged;
	logic [31:0] smp_val;
	logic [31:0] data_left_dec;
	logic        data_last;
	logic        hdr_last;
	logic [10:0] cb;
	logic [42:0] prod_full;

	// a new file restarts the byte count before this byte is taken
	assign idx = cmd.start ? 5'd0 : byte_index_q;

	assign bps  = bits_q[5:3];
	assign lane = idx[1:0];
	assign merged = {8'd0, accum_q} | ({24'd0, data_byte} << {lane, 3'b000});
	assign data_left_dec = data_left_q - 32'd1;
	assign data_last = data_left_dec < {29'd0, bps};

	always_comb begin
		size_next = size_q;
		unique case (idx)
			5'd4:    size_next = {24'd0, data_byte};
			5'd5:    size_next = {size_q[31:16], data_byte, size_q[7:0]};
			5'd6:    size_next = {size_q[31:24], data_byte, size_q[15:0]};
			5'd7:    size_next = {data_byte, size_q[23:0]};
			default: size_next = size_q;
		endcase
	end

	assign hdr_last = size_next < {29'd0, bps};

	always_comb begin
		smp_val = merged;
		unique case (bps)
			3'd1:    smp_val = (merged ^ 32'h0000_0080) << 24;
			3'd2:    smp_val = merged << 16;
			3'd3:    smp_val = merged << 8;
			default: smp_val = merged;
		endcase
	end

	assign cb = 11'(channels_q[4:0] * bits_q[5:0]);
	assign prod_full = rate_q * cb;

	always_comb begin
		status.riff_done   = idx == 5'd11;
		status.riff_ok     = tag_q == wsp_pkg::TAG_RIFF &&
		                     {size_q[23:0], data_byte} == wsp_pkg::TAG_WAVE;
		status.chunk_done  = idx == 5'd7;
		status.tag_fmt     = tag_q == wsp_pkg::TAG_FMT;
		status.tag_data    = tag_q == wsp_pkg::TAG_DATA;
		status.size_zero   = size_next == 32'd0;
		status.skip_one    = skip_left_q == 32'd1;
		status.fmt_last    = idx[3:0] == 4'd15;
		status.sample_done = ({1'b0, lane} + 3'd1) >= bps;
		status.data_end    = data_left_q == 32'd1;
		status.skip_gt16   = skip_left_q > 32'd16;
		status.fmt_ok      = (format_q == wsp_pkg::FMT_PCM || format_q == wsp_pkg::FMT_FLOAT)
		                     && channels_q >= 16'd1 && channels_q <= 16'd16
		                     && (bits_q == 16'd8 || bits_q == 16'd16 ||
		                         bits_q == 16'd24 || bits_q == 16'd32)
		                     && byterate_q == {3'd0, prod_q[31:3]}
		                     && align_q == {8'd0, cb[10:3]};
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_full[31:0];
		case (cmd.op)
			wsp_pkg::OP_RIFF: begin
				if (idx < 5'd4)
					tag_q <= {tag_q[23:0], data_byte};
				else if (idx >= 5'd8)
					size_q <= {size_q[23:0], data_byte};
				byte_index_q <= (idx == 5'd11) ? 5'd0 : idx + 5'd1;
			end
			wsp_pkg::OP_CHUNK: begin
				if (idx < 5'd4)
					tag_q <= {tag_q[23:0], data_byte};
				size_q <= size_next;
				if (idx == 5'd7) begin
					byte_index_q <= 5'd0;
					skip_left_q  <= size_next;
					data_left_q  <= size_next;
					accum_q      <= 24'd0;
				end else begin
					byte_index_q <= idx + 5'd1;
				end
			end
			wsp_pkg::OP_SKIP:   skip_left_q <= skip_left_q - 32'd1;
			wsp_pkg::OP_SKIP16: skip_left_q <= skip_left_q - 32'd16;
			wsp_pkg::OP_FMT: begin
				unique case (idx[3:0])
					4'd0:  format_q[7:0]     <= data_byte;
					4'd1:  format_q[15:8]    <= data_byte;
					4'd2:  channels_q[7:0]   <= data_byte;
					4'd3:  channels_q[15:8]  <= data_byte;
					4'd4:  rate_q[7:0]       <= data_byte;
					4'd5:  rate_q[15:8]      <= data_byte;
					4'd6:  rate_q[23:16]     <= data_byte;
					4'd7:  rate_q[31:24]     <= data_byte;
					4'd8:  byterate_q[7:0]   <= data_byte;
					4'd9:  byterate_q[15:8]  <= data_byte;
					4'd10: byterate_q[23:16] <= data_byte;
					4'd11: byterate_q[31:24] <= data_byte;
					4'd12: align_q[7:0]      <= data_byte;
					4'd13: align_q[15:8]     <= data_byte;
					4'd14: bits_q[7:0]       <= data_byte;
					4'd15: bits_q[15:8]      <= data_byte;
					default: ;
				endcase
				byte_index_q <= {1'b0, idx[3:0] + 4'd1};
			end
			wsp_pkg::OP_DATA: begin
				data_left_q <= data_left_dec;
				if (status.sample_done) begin
					byte_index_q <= 5'd0;
					accum_q      <= 24'd0;
				end else begin
					accum_q      <= merged[23:0];
					byte_index_q <= {3'd0, lane + 2'd1};
				end
			end
			default: ;
		endcase

		if (cmd.out_load) begin
			kind          <= cmd.out_kind;
			sample        <= '0;
			rate_hz       <= '0;
			channel_count <= '0;
			sample_bits   <= '0;
			last          <= 1'b0;
			case (cmd.out_kind)
				wsp_pkg::KIND_SAMPLE: begin
					sample      <= smp_val;
					sample_bits <= bits_q[5:0];
					last        <= data_last;
				end
				wsp_pkg::KIND_HEADER: begin
					rate_hz       <= rate_q;
					channel_count <= channels_q[4:0];
					sample_bits   <= bits_q[5:0];
					last          <= hdr_last;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/wsp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module wsp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              starts_file,
	input  wire logic              ends_file,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire wsp_pkg::status_t  status,
	output wsp_pkg::cmd_t          cmd
);

	wsp_pkg::state_t state_q, state_d;
	wsp_pkg::state_t ph, ph_step;
	logic            end_q;
	logic            slot_busy;
	logic            accept;
	logic            emit;
	wsp_pkg::kind_t  emit_kind;

	assign slot_busy = out_valid && out_stall;
	assign ph = starts_file ? wsp_pkg::ST_RIFF : state_q;

	// phase after this byte, before the end-of-file override
	always_comb begin
		ph_step   = ph;
		emit      = 1'b0;
		emit_kind = wsp_pkg::KIND_INVALID;
		unique case (ph)
			wsp_pkg::ST_RIFF: begin
				if (status.riff_done) begin
					if (status.riff_ok) begin
						ph_step = wsp_pkg::ST_SEEKFMT;
					end else begin
						ph_step = wsp_pkg::ST_DONE;
						emit    = 1'b1;
					end
				end
			end
			wsp_pkg::ST_SEEKFMT: begin
				if (status.chunk_done) begin
					if (status.tag_fmt)
						ph_step = wsp_pkg::ST_FMTBODY;
					else if (!status.size_zero)
						ph_step = wsp_pkg::ST_SKIPFMT;
				end
			end
			wsp_pkg::ST_SKIPFMT: if (status.skip_one) ph_step = wsp_pkg::ST_SEEKFMT;
			wsp_pkg::ST_FMTBODY: if (status.fmt_last) ph_step = wsp_pkg::ST_CHK_MUL;
			wsp_pkg::ST_SEEKDATA: begin
				if (status.chunk_done) begin
					if (status.tag_data) begin
						emit      = 1'b1;
						emit_kind = wsp_pkg::KIND_HEADER;
						ph_step   = status.size_zero ? wsp_pkg::ST_DONE : wsp_pkg::ST_DATA;
					end else if (!status.size_zero) begin
						ph_step = wsp_pkg::ST_SKIPDATA;
					end
				end
			end
			wsp_pkg::ST_SKIPDATA: if (status.skip_one) ph_step = wsp_pkg::ST_SEEKDATA;
			wsp_pkg::ST_DATA: begin
				if (status.sample_done) begin
					emit      = 1'b1;
					emit_kind = wsp_pkg::KIND_SAMPLE;
				end
				if (status.data_end)
					ph_step = wsp_pkg::ST_DONE;
			end
			default: ;
		endcase
		// end of file inside a phase that has not finished overrides any result
		if (ends_file && ph_step != wsp_pkg::ST_DONE && ph_step != wsp_pkg::ST_CHK_MUL) begin
			emit = 1'b1;
			emit_kind = (ph_step == wsp_pkg::ST_RIFF || ph_step == wsp_pkg::ST_FMTBODY ||
			             ph_step == wsp_pkg::ST_DATA) ? wsp_pkg::KIND_TRUNC
			                                          : wsp_pkg::KIND_INVALID;
			ph_step = wsp_pkg::ST_DONE;
		end
	end

	always_comb begin
		in_stall = slot_busy || state_q == wsp_pkg::ST_CHK_MUL ||
		           state_q == wsp_pkg::ST_CHK_CMP;
		accept   = in_valid && !in_stall;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wsp_pkg::ST_CHK_MUL: state_d = wsp_pkg::ST_CHK_CMP;
			wsp_pkg::ST_CHK_CMP: begin
				if (!slot_busy) begin
					if (!status.fmt_ok || end_q)
						state_d = wsp_pkg::ST_DONE;
					else if (status.skip_gt16)
						state_d = wsp_pkg::ST_SKIPDATA;
					else
						state_d = wsp_pkg::ST_SEEKDATA;
				end
			end
			default: if (accept) state_d = ph_step;
		endcase
	end

	always_comb begin
		cmd.op       = wsp_pkg::OP_NONE;
		cmd.start    = starts_file;
		cmd.out_load = 1'b0;
		cmd.out_kind = emit_kind;
		unique case (state_q)
			wsp_pkg::ST_CHK_MUL: ;
			wsp_pkg::ST_CHK_CMP: begin
				cmd.start    = 1'b0;
				cmd.out_kind = wsp_pkg::KIND_INVALID;
				if (!slot_busy) begin
					if (!status.fmt_ok || end_q)
						cmd.out_load = 1'b1;
					else if (status.skip_gt16)
						cmd.op = wsp_pkg::OP_SKIP16;
				end
			end
			default: begin
				if (accept) begin
					cmd.out_load = emit;
					unique case (ph)
						wsp_pkg::ST_RIFF:     cmd.op = wsp_pkg::OP_RIFF;
						wsp_pkg::ST_SEEKFMT,
						wsp_pkg::ST_SEEKDATA: cmd.op = wsp_pkg::OP_CHUNK;
						wsp_pkg::ST_SKIPFMT,
						wsp_pkg::ST_SKIPDATA: cmd.op = wsp_pkg::OP_SKIP;
						wsp_pkg::ST_FMTBODY:  cmd.op = wsp_pkg::OP_FMT;
						wsp_pkg::ST_DATA:     cmd.op = wsp_pkg::OP_DATA;
						default:              cmd.op = wsp_pkg::OP_NONE;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wsp_pkg::ST_RIFF;
			end_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept)
				end_q <= ends_file;
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* rtl/wav_stream_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake           | payload
// input    | in_valid / in_stall | data_byte, starts_file, ends_file
// output   | out_valid/out_stall | kind, sample, rate_hz, channel_count, sample_bits, last
//
// One byte is taken per cycle while the result register is free or being emptied and no fmt check runs.
// After the last fmt byte, input is stalled for the byte-rate multiply
// and then for the field compare.
// Reset returns the parser to waiting for the RIFF header with no result held.
// A held result blocks further transfers only while out_stall is high.
module wav_stream_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               starts_file,
	input  wire logic               ends_file,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              kind,
	output logic signed [31:0]      sample,
	output logic [31:0]             rate_hz,
	output logic [4:0]              channel_count,
	output logic [5:0]              sample_bits,
	output logic                    last
);

	wsp_pkg::cmd_t    cmd;
	wsp_pkg::status_t status;

	wsp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.starts_file (starts_file),
		.ends_file   (ends_file),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.cmd         (cmd)
	);

	wsp_dp u_dp (
		.clk           (clk),
		.data_byte     (data_byte),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.sample        (sample),
		.rate_hz       (rate_hz),
		.channel_count (channel_count),
		.sample_bits   (sample_bits),
		.last          (last)
	);

endmodule
`default_nettype wire
